// ===== src/u8v_pkg.sv =====
`timescale 1ns / 1ps

package u8v_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_WIDTH  = 32;
    localparam int OUT_WIDTH  = 32;
    localparam logic [OUT_WIDTH-1:0] OUT_MAX = {OUT_WIDTH{1'b1}};
    localparam logic [CFG_WIDTH-1:0] MAX_LENGTH_RESET = {CFG_WIDTH{1'b1}};

    // verdict codes
    localparam logic [1:0] VERDICT_OK      = 2'd0;
    localparam logic [1:0] VERDICT_TOO_BIG = 2'd1;
    localparam logic [1:0] VERDICT_NUL     = 2'd2;
    localparam logic [1:0] VERDICT_INVALID = 2'd3;

    // allowed range of the next continuation byte
    localparam int RC_COUNT = 5;
    localparam logic [2:0] RC_ANY   = 3'd0;  // 80..BF
    localparam logic [2:0] RC_A0_BF = 3'd1;
    localparam logic [2:0] RC_80_9F = 3'd2;
    localparam logic [2:0] RC_90_BF = 3'd3;
    localparam logic [2:0] RC_80_8F = 3'd4;

    localparam logic [7:0] NUL_BYTE  = 8'h00;
    localparam logic [7:0] ASCII_HI  = 8'h7F;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_E1   = 8'hE1;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_EF   = 8'hEF;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F1   = 8'hF1;
    localparam logic [7:0] LEAD_F3   = 8'hF3;
    localparam logic [7:0] LEAD_F4   = 8'hF4;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_8F   = 8'h8F;
    localparam logic [7:0] CONT_90   = 8'h90;
    localparam logic [7:0] CONT_9F   = 8'h9F;
    localparam logic [7:0] CONT_A0   = 8'hA0;
    localparam logic [7:0] CONT_HI   = 8'hBF;

    typedef struct packed {
        logic                is_nul;
        logic                last;
        logic [RC_COUNT-1:0] cont_ok;      // byte fits range class n
        logic                lead_bad;     // stray or illegal lead
        logic [1:0]          open_pending; // continuations a lead opens, 0 for none
        logic [2:0]          open_cls;     // range class of its second byte
    } t_byte_class;

    function automatic t_byte_class classify(input logic [7:0] b, input logic last);
        t_byte_class c;
        c = '0;
        c.last   = last;
        c.is_nul = (b == NUL_BYTE);
        c.cont_ok[RC_ANY]   = b inside {[CONT_LO:CONT_HI]};
        c.cont_ok[RC_A0_BF] = b inside {[CONT_A0:CONT_HI]};
        c.cont_ok[RC_80_9F] = b inside {[CONT_LO:CONT_9F]};
        c.cont_ok[RC_90_BF] = b inside {[CONT_90:CONT_HI]};
        c.cont_ok[RC_80_8F] = b inside {[CONT_LO:CONT_8F]};
        case (b) inside
            [NUL_BYTE:ASCII_HI]: begin
            end
            [LEAD2_LO:LEAD2_HI]: begin
                c.open_pending = 2'd1;
                c.open_cls     = RC_ANY;
            end
            LEAD_E0: begin
                c.open_pending = 2'd2;
                c.open_cls     = RC_A0_BF;
            end
            LEAD_ED: begin
                c.open_pending = 2'd2;
                c.open_cls     = RC_80_9F;
            end
            [LEAD_E1:LEAD_EF]: begin
                c.open_pending = 2'd2;
                c.open_cls     = RC_ANY;
            end
            LEAD_F0: begin
                c.open_pending = 2'd3;
                c.open_cls     = RC_90_BF;
            end
            LEAD_F4: begin
                c.open_pending = 2'd3;
                c.open_cls     = RC_80_8F;
            end
            [LEAD_F1:LEAD_F3]: begin
                c.open_pending = 2'd3;
                c.open_cls     = RC_ANY;
            end
            default: begin
                c.lead_bad = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== src/u8v_if.sv =====
`timescale 1ns / 1ps

interface u8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8v_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [31:0] fault_offset;
    logic [31:0] payload_length;

    modport source (output valid, output verdict, output fault_offset,
                    output payload_length, input ready);
    modport sink   (input valid, input verdict, input fault_offset,
                    input payload_length, output ready);
endinterface

interface u8v_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink   (input valid, input max_length, output ready);
endinterface

// ===== src/u8v_front.sv =====
`timescale 1ns / 1ps

module u8v_front (
    u8v_byte_if.sink              i_in,
    input  logic                  i_wr_ready,
    output logic                  o_wr_valid,
    output u8v_pkg::t_byte_class  o_wr_data
);
    import u8v_pkg::*;

    // classify the byte on the way into the queue
    assign i_in.ready = i_wr_ready;
    assign o_wr_valid = i_in.valid;
    assign o_wr_data  = classify(i_in.data_byte, i_in.last_byte);

endmodule

// ===== src/u8v_queue.sv =====
`timescale 1ns / 1ps

module u8v_queue #(
    parameter int DEPTH = u8v_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_valid,
    input  u8v_pkg::t_byte_class  i_wr_data,
    output logic                  o_wr_ready,
    output logic                  o_rd_valid,
    output u8v_pkg::t_byte_class  o_rd_data,
    input  logic                  i_rd_en
);
    import u8v_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_byte_class   r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_wr_ready = (r_cnt != FULL_CNT);
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = i_rd_en && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== src/u8v_back.sv =====
`timescale 1ns / 1ps

module u8v_back #(
    parameter int COUNT_WIDTH = u8v_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [u8v_pkg::CFG_WIDTH-1:0]  i_max_length,
    input  logic                           i_rd_valid,
    input  u8v_pkg::t_byte_class           i_rd_data,
    output logic                           o_rd_en,
    u8v_result_if.source                   o_out
);
    import u8v_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    function automatic logic [OUT_WIDTH-1:0] clamp_out(input logic [COUNT_WIDTH-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (ext > EXT_W'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return ext[OUT_WIDTH-1:0];
    endfunction

    logic [COUNT_WIDTH-1:0] r_count,    n_count;
    logic [1:0]             r_pending,  n_pending;
    logic [2:0]             r_cls,      n_cls;
    logic                   r_await,    n_await;
    logic [COUNT_WIDTH-1:0] r_lead,     n_lead;
    logic                   r_nul_seen, n_nul_seen;
    logic [COUNT_WIDTH-1:0] r_nul_off,  n_nul_off;
    logic                   r_bad_seen, n_bad_seen;
    logic [COUNT_WIDTH-1:0] r_bad_off,  n_bad_off;

    logic                   r_out_valid;
    logic [1:0]             r_verdict,  n_verdict;
    logic [OUT_WIDTH-1:0]   r_fault,    n_fault;
    logic [OUT_WIDTH-1:0]   r_length,   n_length;

    logic                   pop;
    logic                   fin;
    logic                   cont_ok;
    logic [2:0]             cur_cls;
    t_byte_class            c;

    assign c   = i_rd_data;
    // a last byte waits until the output register is free
    assign pop = i_rd_valid && (!c.last || !r_out_valid || o_out.ready);
    assign fin = pop && c.last;
    assign o_rd_en = pop;

    assign o_out.valid          = r_out_valid;
    assign o_out.verdict        = r_verdict;
    assign o_out.fault_offset   = r_fault;
    assign o_out.payload_length = r_length;

    always_comb begin
        cur_cls = r_await ? r_cls : RC_ANY;
        case (cur_cls)
            RC_ANY:   cont_ok = c.cont_ok[RC_ANY];
            RC_A0_BF: cont_ok = c.cont_ok[RC_A0_BF];
            RC_80_9F: cont_ok = c.cont_ok[RC_80_9F];
            RC_90_BF: cont_ok = c.cont_ok[RC_90_BF];
            RC_80_8F: cont_ok = c.cont_ok[RC_80_8F];
            default:  cont_ok = c.cont_ok[RC_ANY];
        endcase
    end

    always_comb begin
        n_count    = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;
        n_pending  = r_pending;
        n_cls      = r_cls;
        n_await    = r_await;
        n_lead     = r_lead;
        n_nul_seen = r_nul_seen;
        n_nul_off  = r_nul_off;
        n_bad_seen = r_bad_seen;
        n_bad_off  = r_bad_off;

        if (c.is_nul && !r_nul_seen) begin
            n_nul_seen = 1'b1;
            n_nul_off  = r_count;
        end

        if (r_pending != 2'd0) begin
            n_await = 1'b0;
            if (cont_ok) begin
                n_pending = r_pending - 2'd1;
            end else begin
                // drop the open sequence, fault at its lead
                n_pending = 2'd0;
                if (!r_bad_seen) begin
                    n_bad_seen = 1'b1;
                    n_bad_off  = r_lead;
                end
            end
        end else if (c.open_pending != 2'd0) begin
            n_pending = c.open_pending;
            n_cls     = c.open_cls;
            n_await   = 1'b1;
            n_lead    = r_count;
        end else if (c.lead_bad && !r_bad_seen) begin
            n_bad_seen = 1'b1;
            n_bad_off  = r_count;
        end

        // truncated sequence at the end of the payload
        if (c.last && n_pending != 2'd0 && !n_bad_seen) begin
            n_bad_seen = 1'b1;
            n_bad_off  = n_lead;
        end

        n_fault = '0;
        if (EXT_W'(n_count) > EXT_W'(i_max_length)) begin
            n_verdict = VERDICT_TOO_BIG;
        end else if (n_nul_seen) begin
            n_verdict = VERDICT_NUL;
            n_fault   = clamp_out(n_nul_off);
        end else if (n_bad_seen) begin
            n_verdict = VERDICT_INVALID;
            n_fault   = clamp_out(n_bad_off);
        end else begin
            n_verdict = VERDICT_OK;
        end
        n_length = clamp_out(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pending   <= '0;
            r_cls       <= RC_ANY;
            r_await     <= 1'b0;
            r_lead      <= '0;
            r_nul_seen  <= 1'b0;
            r_nul_off   <= '0;
            r_bad_seen  <= 1'b0;
            r_bad_off   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fin) begin
                // start the next payload clean
                r_count    <= '0;
                r_pending  <= '0;
                r_cls      <= RC_ANY;
                r_await    <= 1'b0;
                r_lead     <= '0;
                r_nul_seen <= 1'b0;
                r_nul_off  <= '0;
                r_bad_seen <= 1'b0;
                r_bad_off  <= '0;
            end else if (pop) begin
                r_count    <= n_count;
                r_pending  <= n_pending;
                r_cls      <= n_cls;
                r_await    <= n_await;
                r_lead     <= n_lead;
                r_nul_seen <= n_nul_seen;
                r_nul_off  <= n_nul_off;
                r_bad_seen <= n_bad_seen;
                r_bad_off  <= n_bad_off;
            end
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_verdict <= n_verdict;
            r_fault   <= n_fault;
            r_length  <= n_length;
        end
    end

endmodule

// ===== src/utf8_payload_validator_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Fields                                   Transfer
// i_in     in   data_byte[7:0], last_byte                valid && ready
// o_out    out  verdict[1:0], fault_offset[31:0],        valid && ready
//               payload_length[31:0]
// i_cfg    in   max_length[31:0]                         valid && ready (ready always high)
//
// One byte a cycle sustained while o_out accepts results. A byte lands in the classify
// queue the cycle it is transferred and is folded into the payload state when it leaves
// the queue; the result of a last byte shows on o_out the cycle after it leaves the queue.
// The output register stalls only last bytes; bytes queued behind a stalled last byte wait.
// Reset is synchronous, active low: empties the queue, clears payload state, and
// sets max_length to all ones.

module utf8_payload_validator_core #(
    parameter int COUNT_WIDTH = u8v_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = u8v_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8v_byte_if.sink     i_in,
    u8v_result_if.source o_out,
    u8v_cfg_if.sink      i_cfg
);
    import u8v_pkg::*;

    logic [CFG_WIDTH-1:0] r_max_length;
    logic                 wr_valid;
    logic                 wr_ready;
    t_byte_class          wr_data;
    logic                 rd_valid;
    logic                 rd_en;
    t_byte_class          rd_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg.valid) begin
            r_max_length <= i_cfg.max_length;
        end
    end

    u8v_front u_front (
        .i_in       (i_in),
        .i_wr_ready (wr_ready),
        .o_wr_valid (wr_valid),
        .o_wr_data  (wr_data)
    );

    u8v_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (wr_valid),
        .i_wr_data  (wr_data),
        .o_wr_ready (wr_ready),
        .o_rd_valid (rd_valid),
        .o_rd_data  (rd_data),
        .i_rd_en    (rd_en)
    );

    u8v_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_length (r_max_length),
        .i_rd_valid   (rd_valid),
        .i_rd_data    (rd_data),
        .o_rd_en      (rd_en),
        .o_out        (o_out)
    );

endmodule
